// ===== src/s5ch_pkg.sv =====
// ----------------------------------------------------------------------------
// s5ch_pkg
// Shared types and protocol constants for the SOCKS5 client handshake core.
// ----------------------------------------------------------------------------
package s5ch_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_PULL  = 2'd2,
        ACT_RECV  = 2'd3
    } action_e_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_METHOD = 3'd1,
        PH_AUTH   = 3'd2,
        PH_REPLY  = 3'd3,
        PH_DONE   = 3'd4,
        PH_FAILED = 3'd5
    } phase_e_t;

    typedef enum logic [1:0] {
        MSG_NONE    = 2'd0,
        MSG_OFFER   = 2'd1,
        MSG_CREDS   = 2'd2,
        MSG_REQUEST = 2'd3
    } msg_e_t;

    localparam logic [2:0] CFG_DST_IPV4  = 3'd0;
    localparam logic [2:0] CFG_DST_PORT  = 3'd1;
    localparam logic [2:0] CFG_USE_DOM   = 3'd2;
    localparam logic [2:0] CFG_USER_LEN  = 3'd3;
    localparam logic [2:0] CFG_PASS_LEN  = 3'd4;
    localparam logic [2:0] CFG_DOM_LEN   = 3'd5;

    localparam logic [1:0] SEL_USER = 2'd0;
    localparam logic [1:0] SEL_PASS = 2'd1;
    localparam logic [1:0] SEL_DOM  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_VER_METHOD = 3'd1;
    localparam logic [2:0] ERR_NO_CREDS   = 3'd2;
    localparam logic [2:0] ERR_NO_METHOD  = 3'd3;
    localparam logic [2:0] ERR_AUTH       = 3'd4;
    localparam logic [2:0] ERR_VER_REPLY  = 3'd5;
    localparam logic [2:0] ERR_REJECTED   = 3'd6;
    localparam logic [2:0] ERR_ATYP       = 3'd7;

    localparam logic [7:0] SOCKS_VER       = 8'h05;
    localparam logic [7:0] AUTH_VER        = 8'h01;
    localparam logic [7:0] METH_NO_AUTH    = 8'h00;
    localparam logic [7:0] METH_PASSWORD   = 8'h02;
    localparam logic [7:0] REQ_CONNECT     = 8'h01;
    localparam logic [7:0] RSV_BYTE        = 8'h00;
    localparam logic [7:0] ADDR_TYPE_V4    = 8'h01;
    localparam logic [7:0] ADDR_TYPE_NAME  = 8'h03;
    localparam logic [7:0] ADDR_TYPE_V6    = 8'h04;
    localparam logic [7:0] AUTH_OK         = 8'h00;
    localparam logic [7:0] REP_OK          = 8'h00;

    localparam logic [8:0] REPLY_LEN_IPV4  = 9'd10;
    localparam logic [8:0] REPLY_LEN_IPV6  = 9'd22;
    localparam logic [8:0] REPLY_DOM_BASE  = 9'd7;

    typedef struct packed {
        logic [31:0] dst_ipv4;
        logic [15:0] dst_port;
        logic        use_domain;
        logic [7:0]  username_len;
        logic [7:0]  password_len;
        logic [7:0]  domain_len;
    } cfg_t;

    typedef struct packed {
        phase_e_t   phase;
        logic [8:0] count;
        logic [8:0] total;
        logic [7:0] status;
        logic [2:0] fault;
    } rx_state_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       tx_pending;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [2:0] phase;
        logic [2:0] error_code;
        logic [7:0] reply_code;
    } result_t;

endpackage

// ===== src/s5ch_ram.sv =====
// ----------------------------------------------------------------------------
// s5ch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module s5ch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 765
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/s5ch_tx.sv =====
// ----------------------------------------------------------------------------
// s5ch_tx
// Outbound message builder: byte and end mark at the current position, and
// the string store address needed at a given (next) position.
// ----------------------------------------------------------------------------
module s5ch_tx import s5ch_pkg::*; #(
    parameter int MAX_STRING = 255
) (
    input  msg_e_t                              msg,
    input  logic [9:0]                          pos,
    input  cfg_t                                cfg,
    input  logic [7:0]                          store_byte,
    output logic [7:0]                          tx_byte,
    output logic                                tx_last,
    input  msg_e_t                              addr_msg,
    input  logic [9:0]                          addr_pos,
    input  cfg_t                                addr_cfg,
    output logic [$clog2(3*MAX_STRING)-1:0]     rd_addr
);

    localparam int         AW       = $clog2(3 * MAX_STRING);
    localparam logic [7:0] MAX8     = 8'(MAX_STRING);
    localparam logic [10:0] BASE_PW  = 11'(MAX_STRING);
    localparam logic [10:0] BASE_DOM = 11'(2 * MAX_STRING);

    function automatic logic [7:0] clamp8(input logic [7:0] v);
        return (v > MAX8) ? MAX8 : v;
    endfunction

    logic [10:0] p;
    logic [10:0] ulc;
    logic [10:0] plc;
    logic [10:0] dlc;
    logic        up;
    logic [10:0] len;
    logic [10:0] ap;
    logic [10:0] aulc;
    logic [10:0] addr;

    assign p   = {1'b0, pos};
    assign ulc = {3'b0, clamp8(cfg.username_len)};
    assign plc = {3'b0, clamp8(cfg.password_len)};
    assign dlc = {3'b0, clamp8(cfg.domain_len)};
    assign up  = (cfg.username_len != 8'd0);

    always_comb begin
        len     = 11'd0;
        tx_byte = 8'd0;
        case (msg)
            MSG_OFFER: begin
                len = up ? 11'd4 : 11'd3;
                if (p == 11'd0) begin
                    tx_byte = SOCKS_VER;
                end else if (p == 11'd1) begin
                    tx_byte = up ? 8'd2 : 8'd1;
                end else if (p == 11'd2) begin
                    tx_byte = METH_NO_AUTH;
                end else if (p == 11'd3 && up) begin
                    tx_byte = METH_PASSWORD;
                end
            end
            MSG_CREDS: begin
                len = 11'd3 + ulc + plc;
                if (p == 11'd0) begin
                    tx_byte = AUTH_VER;
                end else if (p == 11'd1) begin
                    tx_byte = ulc[7:0];
                end else if (p < 11'd2 + ulc) begin
                    tx_byte = store_byte;
                end else if (p == 11'd2 + ulc) begin
                    tx_byte = plc[7:0];
                end else if (p < 11'd3 + ulc + plc) begin
                    tx_byte = store_byte;
                end
            end
            MSG_REQUEST: begin
                len = cfg.use_domain ? (11'd7 + dlc) : 11'd10;
                if (p == 11'd0) begin
                    tx_byte = SOCKS_VER;
                end else if (p == 11'd1) begin
                    tx_byte = REQ_CONNECT;
                end else if (p == 11'd2) begin
                    tx_byte = RSV_BYTE;
                end else if (cfg.use_domain) begin
                    if (p == 11'd3) begin
                        tx_byte = ADDR_TYPE_NAME;
                    end else if (p == 11'd4) begin
                        tx_byte = dlc[7:0];
                    end else if (p < 11'd5 + dlc) begin
                        tx_byte = store_byte;
                    end else if (p == 11'd5 + dlc) begin
                        tx_byte = cfg.dst_port[15:8];
                    end else if (p == 11'd6 + dlc) begin
                        tx_byte = cfg.dst_port[7:0];
                    end
                end else begin
                    case (p)
                        11'd3:   tx_byte = ADDR_TYPE_V4;
                        11'd4:   tx_byte = cfg.dst_ipv4[31:24];
                        11'd5:   tx_byte = cfg.dst_ipv4[23:16];
                        11'd6:   tx_byte = cfg.dst_ipv4[15:8];
                        11'd7:   tx_byte = cfg.dst_ipv4[7:0];
                        11'd8:   tx_byte = cfg.dst_port[15:8];
                        11'd9:   tx_byte = cfg.dst_port[7:0];
                        default: tx_byte = 8'd0;
                    endcase
                end
            end
            default: begin
                len     = 11'd0;
                tx_byte = 8'd0;
            end
        endcase
    end

    assign tx_last = ((p + 11'd1) >= len);

    // store address for the position that the next item will see
    assign ap   = {1'b0, addr_pos};
    assign aulc = {3'b0, clamp8(addr_cfg.username_len)};

    always_comb begin
        case (addr_msg)
            MSG_CREDS: begin
                if (ap < 11'd2 + aulc) begin
                    addr = ap - 11'd2;
                end else begin
                    addr = BASE_PW + ap - 11'd3 - aulc;
                end
            end
            MSG_REQUEST: addr = BASE_DOM + ap - 11'd5;
            default:     addr = 11'd0;
        endcase
    end

    assign rd_addr = addr[AW-1:0];

endmodule

// ===== src/s5ch_rx.sv =====
// ----------------------------------------------------------------------------
// s5ch_rx
// Server byte parser: method reply, auth status and connect reply.
// ----------------------------------------------------------------------------
module s5ch_rx import s5ch_pkg::*; (
    input  rx_state_t  cur,
    input  logic [7:0] rx_byte,
    input  logic       user_set,
    output rx_state_t  nxt,
    output msg_e_t     queue
);

    logic [8:0] cnt_inc;
    logic [8:0] total_w;

    assign cnt_inc = cur.count + 9'd1;

    always_comb begin
        nxt     = cur;
        queue   = MSG_NONE;
        total_w = cur.total;
        case (cur.phase)
            PH_METHOD: begin
                if (cur.count == 9'd0) begin
                    if (rx_byte != SOCKS_VER) begin
                        nxt.fault = ERR_VER_METHOD;
                    end
                    nxt.count = 9'd1;
                end else begin
                    nxt.count = 9'd0;
                    if (cur.fault != ERR_NONE) begin
                        nxt.phase = PH_FAILED;
                    end else if (rx_byte == METH_NO_AUTH) begin
                        queue     = MSG_REQUEST;
                        nxt.phase = PH_REPLY;
                        nxt.total = 9'd0;
                        nxt.fault = ERR_NONE;
                    end else if (rx_byte == METH_PASSWORD) begin
                        if (!user_set) begin
                            nxt.phase = PH_FAILED;
                            nxt.fault = ERR_NO_CREDS;
                        end else begin
                            queue     = MSG_CREDS;
                            nxt.phase = PH_AUTH;
                        end
                    end else begin
                        nxt.phase = PH_FAILED;
                        nxt.fault = ERR_NO_METHOD;
                    end
                end
            end
            PH_AUTH: begin
                if (cur.count == 9'd0) begin
                    nxt.count = 9'd1;
                end else begin
                    nxt.count = 9'd0;
                    if (rx_byte != AUTH_OK) begin
                        nxt.phase = PH_FAILED;
                        nxt.fault = ERR_AUTH;
                    end else begin
                        queue     = MSG_REQUEST;
                        nxt.phase = PH_REPLY;
                        nxt.total = 9'd0;
                        nxt.fault = ERR_NONE;
                    end
                end
            end
            PH_REPLY: begin
                if (cur.count == 9'd0 && rx_byte != SOCKS_VER) begin
                    nxt.fault = ERR_VER_REPLY;
                end
                if (cur.count == 9'd1) begin
                    nxt.status = rx_byte;
                end
                if (cur.count == 9'd3 && cur.fault != ERR_NONE) begin
                    nxt.phase = PH_FAILED;
                    nxt.count = 9'd0;
                end else if (cur.count == 9'd3 && cur.status != REP_OK) begin
                    nxt.phase = PH_FAILED;
                    nxt.fault = ERR_REJECTED;
                    nxt.count = 9'd0;
                end else if (cur.count == 9'd3 && rx_byte != ADDR_TYPE_V4
                             && rx_byte != ADDR_TYPE_V6 && rx_byte != ADDR_TYPE_NAME) begin
                    nxt.phase = PH_FAILED;
                    nxt.fault = ERR_ATYP;
                    nxt.count = 9'd0;
                end else begin
                    if (cur.count == 9'd3) begin
                        if (rx_byte == ADDR_TYPE_V4) begin
                            total_w = REPLY_LEN_IPV4;
                        end else if (rx_byte == ADDR_TYPE_V6) begin
                            total_w = REPLY_LEN_IPV6;
                        end else begin
                            total_w = 9'd0;
                        end
                    end
                    if (cur.count == 9'd4 && cur.total == 9'd0) begin
                        total_w = REPLY_DOM_BASE + {1'b0, rx_byte};
                    end
                    nxt.total = total_w;
                    nxt.count = cnt_inc;
                    if (cur.count >= 9'd3 && total_w != 9'd0 && cnt_inc >= total_w) begin
                        nxt.phase = PH_DONE;
                        nxt.count = 9'd0;
                    end
                end
            end
            default: begin
                nxt   = cur;
                queue = MSG_NONE;
            end
        endcase
    end

endmodule

// ===== src/socks5_client_handshake_core.sv =====
// An item waits in the input register until the result register is empty or being read out.
// Throughput: one item per cycle while the result register is not stalled, set by
// the state update and the string RAM read, which is addressed from the next state.
// Reset: synchronous, active low; clears control state and the configuration
// registers, but the string store is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// socks5_client_handshake_core
// SOCKS5 CONNECT client handshake engine with username/password auth.
// ----------------------------------------------------------------------------
module socks5_client_handshake_core import s5ch_pkg::*; #(
    parameter int MAX_STRING = 255
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [1:0]  s_string_select,
    input  logic [7:0]  s_string_index,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_last,
    output logic        m_tx_pending,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [2:0]  m_phase,
    output logic [2:0]  m_error_code,
    output logic [7:0]  m_reply_code
);

    localparam int          AW      = $clog2(3 * MAX_STRING);
    localparam int          DEPTH   = 3 * MAX_STRING;
    localparam logic [8:0]  MAX9    = 9'(MAX_STRING);
    localparam logic [10:0] BASE_PW  = 11'(MAX_STRING);
    localparam logic [10:0] BASE_DOM = 11'(2 * MAX_STRING);

    cfg_t       cfg_reg, cfg_next;
    logic       in_valid_reg;
    action_e_t  in_action_reg;
    logic [1:0] in_sel_reg;
    logic [7:0] in_idx_reg;
    logic [7:0] in_data_reg;

    msg_e_t     msg_reg, msg_next;
    logic [9:0] pos_reg, pos_next;
    rx_state_t  rx_reg, rx_next;
    rx_state_t  rx_parsed;
    msg_e_t     rx_queue;

    logic       m_valid_reg;
    result_t    res_reg, res_next;

    logic       byp_valid_reg;
    logic [7:0] byp_data_reg;

    logic          advance;
    logic          mem_we;
    logic [10:0]   waddr_w;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    mem_rdata;
    logic [7:0]    store_byte;
    logic [7:0]    gen_byte;
    logic          gen_last;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_DST_IPV4: cfg_next.dst_ipv4     = cfg_data;
                CFG_DST_PORT: cfg_next.dst_port     = cfg_data[15:0];
                CFG_USE_DOM:  cfg_next.use_domain   = cfg_data[0];
                CFG_USER_LEN: cfg_next.username_len = cfg_data[7:0];
                CFG_PASS_LEN: cfg_next.password_len = cfg_data[7:0];
                CFG_DOM_LEN:  cfg_next.domain_len   = cfg_data[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_action_reg <= action_e_t'(s_action);
            in_sel_reg    <= s_string_select;
            in_idx_reg    <= s_string_index;
            in_data_reg   <= s_data_byte;
        end
    end

    // string store
    always_comb begin
        case (in_sel_reg)
            SEL_PASS: waddr_w = BASE_PW + {3'b0, in_idx_reg};
            SEL_DOM:  waddr_w = BASE_DOM + {3'b0, in_idx_reg};
            default:  waddr_w = {3'b0, in_idx_reg};
        endcase
    end

    assign mem_waddr = waddr_w[AW-1:0];

    s5ch_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_data_reg),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // write in the same cycle as the prefetch read of that entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= mem_we && (mem_waddr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= in_data_reg;
    end

    assign store_byte = byp_valid_reg ? byp_data_reg : mem_rdata;

    s5ch_tx #(
        .MAX_STRING (MAX_STRING)
    ) u_tx (
        .msg        (msg_reg),
        .pos        (pos_reg),
        .cfg        (cfg_reg),
        .store_byte (store_byte),
        .tx_byte    (gen_byte),
        .tx_last    (gen_last),
        .addr_msg   (msg_next),
        .addr_pos   (pos_next),
        .addr_cfg   (cfg_next),
        .rd_addr    (rd_addr)
    );

    s5ch_rx u_rx (
        .cur      (rx_reg),
        .rx_byte  (in_data_reg),
        .user_set (cfg_reg.username_len != 8'd0),
        .nxt      (rx_parsed),
        .queue    (rx_queue)
    );

    // item processing
    always_comb begin
        msg_next = msg_reg;
        pos_next = pos_reg;
        rx_next  = rx_reg;
        mem_we   = 1'b0;
        res_next = '0;
        if (advance) begin
            case (in_action_reg)
                ACT_LOAD: begin
                    mem_we = (in_sel_reg == SEL_USER || in_sel_reg == SEL_PASS
                              || in_sel_reg == SEL_DOM) && ({1'b0, in_idx_reg} < MAX9);
                end
                ACT_START: begin
                    msg_next = MSG_OFFER;
                    pos_next = 10'd0;
                    rx_next  = '{phase: PH_METHOD, count: 9'd0, total: 9'd0,
                                 status: 8'd0, fault: ERR_NONE};
                end
                ACT_PULL: begin
                    if (msg_reg != MSG_NONE) begin
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = gen_byte;
                        res_next.tx_last  = gen_last;
                        if (gen_last) begin
                            msg_next = MSG_NONE;
                            pos_next = 10'd0;
                        end else begin
                            pos_next = pos_reg + 10'd1;
                        end
                    end
                end
                ACT_RECV: begin
                    if (rx_reg.phase == PH_DONE) begin
                        res_next.payload_valid = 1'b1;
                        res_next.payload_byte  = in_data_reg;
                    end else begin
                        rx_next = rx_parsed;
                        if (rx_queue != MSG_NONE) begin
                            msg_next = rx_queue;
                            pos_next = 10'd0;
                        end
                    end
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
        res_next.tx_pending = (msg_next != MSG_NONE);
        res_next.phase      = rx_next.phase;
        res_next.error_code = (rx_next.phase == PH_FAILED) ? rx_next.fault : ERR_NONE;
        res_next.reply_code = (rx_next.phase == PH_FAILED && rx_next.fault == ERR_REJECTED)
                              ? rx_next.status : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_reg <= MSG_NONE;
            pos_reg <= 10'd0;
            rx_reg  <= '{phase: PH_IDLE, count: 9'd0, total: 9'd0,
                         status: 8'd0, fault: ERR_NONE};
        end else begin
            msg_reg <= msg_next;
            pos_reg <= pos_next;
            rx_reg  <= rx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_tx_valid      = res_reg.tx_valid;
    assign m_tx_byte       = res_reg.tx_byte;
    assign m_tx_last       = res_reg.tx_last;
    assign m_tx_pending    = res_reg.tx_pending;
    assign m_payload_valid = res_reg.payload_valid;
    assign m_payload_byte  = res_reg.payload_byte;
    assign m_phase         = res_reg.phase;
    assign m_error_code    = res_reg.error_code;
    assign m_reply_code    = res_reg.reply_code;

    a_err_only_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |-> (m_phase == PH_FAILED))
        else $error("error code outside failed phase");

    a_last_ends_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid && m_tx_last) |-> !m_tx_pending)
        else $error("message still pending after last byte");

    a_payload_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload_valid) |-> (m_phase == PH_DONE && !m_tx_valid))
        else $error("payload outside done phase");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    a_short_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_reg.phase == PH_METHOD || rx_reg.phase == PH_AUTH) |-> (rx_reg.count <= 9'd1))
        else $error("two-byte reply count overrun");

endmodule

// ===== test/socks5_client_handshake_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// socks5_client_handshake_core_tb
// Self-checking bench for the SOCKS5 client handshake core. Items go in through
// the valid/ready input channel. A cycle-free predictor of the handshake
// computes the result that each accepted item should produce. A checker
// compares every result from the core, field by field, with the oldest
// prediction.
// Directed items cover the error paths, restarts, ignored loads and register
// changes in the middle of a message. Random sessions then run through many
// register settings. Each session is a server conversation, mostly well
// formed, with pulls and noise mixed in. Sender gaps and receiver stalls
// vary from session to session.
// ----------------------------------------------------------------------------
module socks5_client_handshake_core_tb import s5ch_pkg::*; ();

    localparam int MAX_STR        = 255;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_GOAL      = 950;

    localparam logic [2:0] CFG_SPARE   = 3'd6;
    localparam logic [2:0] CFG_NO_REG  = 3'd7;
    localparam logic [1:0] SEL_INVALID = 2'd3;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic [2:0]  cfg_index       = '0;
    logic [31:0] cfg_data        = '0;
    logic        s_valid         = 1'b0;
    logic [1:0]  s_action        = '0;
    logic [1:0]  s_string_select = '0;
    logic [7:0]  s_string_index  = '0;
    logic [7:0]  s_data_byte     = '0;
    logic        m_ready         = 1'b0;
    logic        cfg_ready;
    logic        s_ready;
    logic        m_valid;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_tx_last;
    logic        m_tx_pending;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [2:0]  m_phase;
    logic [2:0]  m_error_code;
    logic [7:0]  m_reply_code;

    socks5_client_handshake_core #(.MAX_STRING(MAX_STR)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_string_select (s_string_select),
        .s_string_index  (s_string_index),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_valid      (m_tx_valid),
        .m_tx_byte       (m_tx_byte),
        .m_tx_last       (m_tx_last),
        .m_tx_pending    (m_tx_pending),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_phase         (m_phase),
        .m_error_code    (m_error_code),
        .m_reply_code    (m_reply_code)
    );

    always #1 aclk = ~aclk;

    // handshake predictor state
    cfg_t       regs    = '0;
    phase_e_t   ph      = PH_IDLE;
    msg_e_t     msg     = MSG_NONE;
    logic [9:0] pos     = '0;
    logic [8:0] cnt     = '0;
    logic [8:0] total   = '0;
    logic [7:0] status  = '0;
    logic [2:0] fault   = ERR_NONE;
    logic [7:0] strings [0:3*MAX_STR-1];
    bit         loaded  [0:3*MAX_STR-1];

    result_t results_due[$];
    int      mismatches     = 0;
    int      items_sent     = 0;
    int      send_idle_pct  = 0;
    int      stall_pct      = 0;
    int      stalled_cycles = 0;

    function automatic int msg_len();
        case (msg)
            MSG_OFFER:   return (regs.username_len != 0) ? 4 : 3;
            MSG_CREDS:   return 3 + int'(regs.username_len) + int'(regs.password_len);
            MSG_REQUEST: return regs.use_domain ? 7 + int'(regs.domain_len) : 10;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [7:0] str_at(int sel, int idx);
        return strings[sel * MAX_STR + idx];
    endfunction

    function automatic logic [7:0] msg_at(int p);
        int ul, pl, dl;
        ul = regs.username_len;
        pl = regs.password_len;
        dl = regs.domain_len;
        case (msg)
            MSG_OFFER: begin
                if (p == 0) return SOCKS_VER;
                if (p == 1) return (ul != 0) ? 8'd2 : 8'd1;
                if (p == 2) return METH_NO_AUTH;
                if (p == 3 && ul != 0) return METH_PASSWORD;
                return 8'h00;
            end
            MSG_CREDS: begin
                if (p == 0) return AUTH_VER;
                if (p == 1) return 8'(ul);
                if (p < 2 + ul) return str_at(SEL_USER, p - 2);
                if (p == 2 + ul) return 8'(pl);
                if (p < 3 + ul + pl) return str_at(SEL_PASS, p - 3 - ul);
                return 8'h00;
            end
            MSG_REQUEST: begin
                if (p == 0) return SOCKS_VER;
                if (p == 1) return REQ_CONNECT;
                if (p == 2) return RSV_BYTE;
                if (regs.use_domain) begin
                    if (p == 3) return ADDR_TYPE_NAME;
                    if (p == 4) return 8'(dl);
                    if (p < 5 + dl) return str_at(SEL_DOM, p - 5);
                    if (p == 5 + dl) return regs.dst_port[15:8];
                    if (p == 6 + dl) return regs.dst_port[7:0];
                    return 8'h00;
                end
                if (p == 3) return ADDR_TYPE_V4;
                if (p < 8) return 8'(regs.dst_ipv4 >> (8 * (7 - p)));
                if (p == 8) return regs.dst_port[15:8];
                if (p == 9) return regs.dst_port[7:0];
                return 8'h00;
            end
            default: return 8'h00;
        endcase
    endfunction

    function automatic void go_failed(logic [2:0] code);
        fault = code;
        ph    = PH_FAILED;
        cnt   = '0;
    endfunction

    function automatic void go_reply();
        msg   = MSG_REQUEST;
        pos   = '0;
        ph    = PH_REPLY;
        cnt   = '0;
        total = '0;
        fault = ERR_NONE;
    endfunction

    function automatic void take_rx_byte(logic [7:0] b);
        int i;
        case (ph)
            PH_METHOD: begin
                if (cnt == 0) begin
                    if (b != SOCKS_VER) fault = ERR_VER_METHOD;
                    cnt = 9'd1;
                end else begin
                    cnt = '0;
                    if (fault != ERR_NONE) go_failed(fault);
                    else if (b == METH_NO_AUTH) go_reply();
                    else if (b == METH_PASSWORD) begin
                        if (regs.username_len == 0) go_failed(ERR_NO_CREDS);
                        else begin
                            msg = MSG_CREDS;
                            pos = '0;
                            ph  = PH_AUTH;
                        end
                    end else go_failed(ERR_NO_METHOD);
                end
            end
            PH_AUTH: begin
                if (cnt == 0) cnt = 9'd1;
                else begin
                    cnt = '0;
                    if (b != AUTH_OK) go_failed(ERR_AUTH);
                    else go_reply();
                end
            end
            PH_REPLY: begin
                i = cnt;
                if (i == 0 && b != SOCKS_VER) fault = ERR_VER_REPLY;
                if (i == 1) status = b;
                if (i == 3) begin
                    if (fault != ERR_NONE) begin
                        go_failed(fault);
                        return;
                    end
                    if (status != REP_OK) begin
                        go_failed(ERR_REJECTED);
                        return;
                    end
                    if (b == ADDR_TYPE_V4) total = REPLY_LEN_IPV4;
                    else if (b == ADDR_TYPE_V6) total = REPLY_LEN_IPV6;
                    else if (b == ADDR_TYPE_NAME) total = '0;
                    else begin
                        go_failed(ERR_ATYP);
                        return;
                    end
                end
                if (i == 4 && total == 0) total = REPLY_DOM_BASE + b;
                cnt = 9'(i + 1);
                if (i >= 3 && total != 0 && cnt >= total) begin
                    ph  = PH_DONE;
                    cnt = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic result_t advance_handshake(action_e_t act, logic [1:0] sel,
                                                  logic [7:0] idx, logic [7:0] b);
        result_t r;
        int      len;
        r = '0;
        case (act)
            ACT_LOAD: begin
                if (sel <= SEL_DOM && idx < MAX_STR) begin
                    strings[sel * MAX_STR + idx] = b;
                    loaded[sel * MAX_STR + idx]  = 1'b1;
                end
            end
            ACT_START: begin
                msg    = MSG_OFFER;
                pos    = '0;
                ph     = PH_METHOD;
                cnt    = '0;
                total  = '0;
                status = '0;
                fault  = ERR_NONE;
            end
            ACT_PULL: begin
                if (msg != MSG_NONE) begin
                    len        = msg_len();
                    r.tx_valid = 1'b1;
                    r.tx_byte  = msg_at(pos);
                    if (int'(pos) + 1 >= len) begin
                        r.tx_last = 1'b1;
                        msg       = MSG_NONE;
                        pos       = '0;
                    end else begin
                        pos = pos + 10'd1;
                    end
                end
            end
            default: begin
                if (ph == PH_DONE) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                end else begin
                    take_rx_byte(b);
                end
            end
        endcase
        r.tx_pending = (msg != MSG_NONE);
        r.phase      = ph;
        r.error_code = (ph == PH_FAILED) ? fault : ERR_NONE;
        r.reply_code = (ph == PH_FAILED && fault == ERR_REJECTED) ? status : 8'h00;
        return r;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("tx %0b/%02h/%0b pend %0b pay %0b/%02h phase %0d err %0d rep %02h",
                         r.tx_valid, r.tx_byte, r.tx_last, r.tx_pending, r.payload_valid,
                         r.payload_byte, r.phase, r.error_code, r.reply_code);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : check_results
        result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_tx_valid, m_tx_byte, m_tx_last, m_tx_pending, m_payload_valid,
                   m_payload_byte, m_phase, m_error_code, m_reply_code};
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %s", show(got));
            end else begin
                want = results_due.pop_front();
                if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                    got.tx_last !== want.tx_last || got.tx_pending !== want.tx_pending ||
                    got.payload_valid !== want.payload_valid ||
                    got.payload_byte !== want.payload_byte || got.phase !== want.phase ||
                    got.error_code !== want.error_code ||
                    got.reply_code !== want.reply_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %s, got %s", show(want), show(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", stalled_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic set_pacing(int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 73; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
        endcase
    endtask

    task automatic send_item(action_e_t act, logic [1:0] sel, logic [7:0] idx,
                             logic [7:0] data);
        result_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= act;
        s_string_select <= sel;
        s_string_index  <= idx;
        s_data_byte     <= data;
        do @(posedge aclk); while (!s_ready);
        want = advance_handshake(act, sel, idx, data);
        results_due = {results_due, want};
        items_sent++;
    endtask

    task automatic pull();
        send_item(ACT_PULL, 2'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic recv(logic [7:0] b);
        send_item(ACT_RECV, 2'($urandom), 8'($urandom), b);
    endtask

    task automatic start();
        send_item(ACT_START, 2'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value, int width);
        logic [31:0] data;
        data = (width >= 32) ? value : (value | ($urandom << width));
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DST_IPV4: regs.dst_ipv4     = data;
            CFG_DST_PORT: regs.dst_port     = data[15:0];
            CFG_USE_DOM:  regs.use_domain   = data[0];
            CFG_USER_LEN: regs.username_len = data[7:0];
            CFG_PASS_LEN: regs.password_len = data[7:0];
            CFG_DOM_LEN:  regs.domain_len   = data[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // every store byte that a message can read must be written first
    task automatic ensure_loaded();
        int lens[3];
        lens[0] = regs.username_len;
        lens[1] = regs.password_len;
        lens[2] = regs.domain_len;
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < lens[s]; i++)
                if (!loaded[s * MAX_STR + i])
                    send_item(ACT_LOAD, 2'(s), 8'(i), 8'($urandom));
    endtask

    task automatic apply_config(logic [31:0] ip, logic [15:0] port, logic dom,
                                logic [7:0] ul, logic [7:0] pl, logic [7:0] dl);
        write_reg(CFG_DST_IPV4, ip, 32);
        write_reg(CFG_DST_PORT, 32'(port), 16);
        write_reg(CFG_USE_DOM, 32'(dom), 1);
        write_reg(CFG_USER_LEN, 32'(ul), 8);
        write_reg(CFG_PASS_LEN, 32'(pl), 8);
        write_reg(CFG_DOM_LEN, 32'(dl), 8);
        ensure_loaded();
    endtask

    // one server conversation; clean sessions follow the success path
    task automatic run_session(bit clean);
        logic [7:0] srv[$];
        logic [7:0] mver, meth, atyp, dlen;
        int         r;
        mver = (!clean && $urandom_range(99) < 8) ? 8'($urandom) : SOCKS_VER;
        r = $urandom_range(99);
        if (!clean && r < 10) meth = 8'($urandom);
        else if ((regs.username_len != 0) ? (r < 60) : (!clean && r < 20))
            meth = METH_PASSWORD;
        else meth = METH_NO_AUTH;
        srv = {srv, mver};
        srv = {srv, meth};
        if (mver == SOCKS_VER && meth == METH_PASSWORD && regs.username_len != 0) begin
            srv = {srv, 8'($urandom)};
            srv = {srv, (!clean && $urandom_range(99) < 15) ? 8'($urandom) : AUTH_OK};
        end
        srv = {srv, (!clean && $urandom_range(99) < 8) ? 8'($urandom) : SOCKS_VER};
        srv = {srv, (!clean && $urandom_range(99) < 15) ? 8'($urandom) : REP_OK};
        srv = {srv, 8'($urandom)};
        r = $urandom_range(99);
        if (!clean && r >= 94) atyp = 8'($urandom);
        else if (r < 40) atyp = ADDR_TYPE_V4;
        else if (r < 65) atyp = ADDR_TYPE_V6;
        else atyp = ADDR_TYPE_NAME;
        srv = {srv, atyp};
        if (atyp == ADDR_TYPE_V4) repeat (6) srv = {srv, 8'($urandom)};
        else if (atyp == ADDR_TYPE_V6) repeat (18) srv = {srv, 8'($urandom)};
        else if (atyp == ADDR_TYPE_NAME) begin
            dlen = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 10)) : 8'($urandom);
            srv = {srv, dlen};
            repeat (int'(dlen) + 2) srv = {srv, 8'($urandom)};
        end
        repeat ($urandom_range(0, 6)) srv = {srv, 8'($urandom)};

        start();
        while (srv.size() != 0 || msg != MSG_NONE) begin
            r = $urandom_range(99);
            if (srv.size() != 0 && r < 45) recv(srv.pop_front());
            else if (clean || r < 88) pull();
            else if (r < 96) send_item(ACT_LOAD, 2'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 98) recv(8'($urandom));
            else start();
        end
    endtask

    function automatic logic [31:0] pick_edge(int width);
        int r;
        r = $urandom_range(99);
        if (r < 20) return '0;
        if (r < 40) return (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
        return (width >= 32) ? $urandom : ($urandom & ((32'd1 << width) - 1));
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 8'd0;
        if (r < 90) return 8'($urandom_range(1, 6));
        return 8'($urandom_range(7, 40));
    endfunction

    task automatic test_directed_basics();
        set_pacing(0);
        pull();
        recv(8'hFF);
        send_item(ACT_LOAD, SEL_INVALID, 8'd0, 8'hFF);
        send_item(ACT_LOAD, SEL_USER, 8'd255, 8'hAA);
        send_item(ACT_LOAD, SEL_DOM, 8'd254, 8'h00);
        start();
        repeat (3) pull();
        recv(SOCKS_VER);
        recv(METH_NO_AUTH);
        pull();
        start();
        pull();
        recv(8'h04);
        recv(METH_NO_AUTH);
        recv(8'h11);
        start();
        recv(SOCKS_VER);
        recv(METH_PASSWORD);
        start();
        recv(SOCKS_VER);
        recv(8'hFF);
    endtask

    task automatic test_live_registers();
        set_pacing(3);
        write_reg(CFG_USER_LEN, 32'd2, 8);
        write_reg(CFG_PASS_LEN, 32'd2, 8);
        ensure_loaded();
        start();
        recv(SOCKS_VER);
        recv(METH_PASSWORD);
        repeat (4) pull();
        // shrink the credentials under the queued message
        write_reg(CFG_USER_LEN, 32'd0, 8);
        write_reg(CFG_PASS_LEN, 32'd0, 8);
        pull();
        start();
        pull();
        write_reg(CFG_USER_LEN, 32'd5, 8);
        ensure_loaded();
        repeat (3) pull();
        recv(SOCKS_VER);
        recv(METH_NO_AUTH);
        repeat (9) pull();
        write_reg(CFG_USE_DOM, 32'd1, 1);
        write_reg(CFG_DOM_LEN, 32'd0, 8);
        pull();
        write_reg(CFG_SPARE, $urandom, 32);
        write_reg(CFG_NO_REG, $urandom, 32);
    endtask

    task automatic test_register_extremes();
        apply_config(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'd0, 8'd0, 8'd255);
        set_pacing(0);
        run_session(1'b1);
        apply_config(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 8'd1, 8'd1, 8'd0);
        set_pacing(1);
        run_session(1'b0);
    endtask

    task automatic test_random_sessions();
        int phase_no;
        phase_no = 0;
        while (items_sent < ITEM_GOAL) begin
            if (phase_no == 0) apply_config('0, '0, 1'b0, '0, '0, '0);
            else apply_config(pick_edge(32), 16'(pick_edge(16)), 1'($urandom),
                              pick_len(), pick_len(), pick_len());
            for (int k = 0; k < 6 && items_sent < ITEM_GOAL; k++) begin
                set_pacing((phase_no + k) % 4);
                run_session($urandom_range(99) < 60);
            end
            phase_no++;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_basics();
        test_live_registers();
        test_register_extremes();
        test_random_sessions();
        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
